/* design/sole_pkg.sv */
package sole_pkg;

    // Field widths
    localparam int ACC_W    = 16;
    localparam int WGT_W    = 16;
    localparam int CLAMP_W  = 15;
    localparam int QUANT_W  = 15;
    localparam int SCALE_W  = 16;
    localparam int BIAS_W   = 16;
    localparam int SUM_W    = 32;
    localparam int EVAL_W   = 32;

    // Shared multiplier operand and product widths
    localparam int MA_W     = 34;
    localparam int MB_W     = 17;
    localparam int PROD_W   = MA_W + MB_W;

    // Shared divider widths
    localparam int DVD_W    = 49;
    localparam int DSR_W    = 30;
    localparam int DCNT_W   = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLAMP_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUTPUT_QUANT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EVAL_SCALE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUTPUT_BIAS  = 2'd3;

    localparam logic [CLAMP_W-1:0]        RST_CLAMP_LIMIT  = 15'd255;
    localparam logic [QUANT_W-1:0]        RST_OUTPUT_QUANT = 15'd64;
    localparam logic [SCALE_W-1:0]        RST_EVAL_SCALE   = 16'd400;
    localparam logic signed [BIAS_W-1:0]  RST_OUTPUT_BIAS  = 16'sd0;

    localparam logic signed [EVAL_W-1:0] EVAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [EVAL_W-1:0] EVAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DSR_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } t_div_rsp;

endpackage

/* design/sole_ifs.sv */
interface sole_in_if;
    import sole_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  wht_accum;
    logic signed [ACC_W-1:0]  blk_accum;
    logic signed [WGT_W-1:0]  own_weight;
    logic signed [WGT_W-1:0]  other_weight;
    logic                     white_moves;
    logic                     last_neuron;

    modport source (
        output valid, wht_accum, blk_accum, own_weight, other_weight,
               white_moves, last_neuron,
        input  ready
    );
    modport sink (
        input  valid, wht_accum, blk_accum, own_weight, other_weight,
               white_moves, last_neuron,
        output ready
    );
endinterface

interface sole_out_if;
    import sole_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [EVAL_W-1:0]  evaluation;

    modport source (output valid, evaluation, input ready);
    modport sink (input valid, evaluation, output ready);
endinterface

interface sole_cfg_if;
    import sole_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/screlu_output_layer_eval_core.sv */
// SCReLU output layer evaluator, fed one hidden neuron per transfer.
//
// Input channel: each transfer carries both perspective accumulators of one
// neuron, its two output weights, the side-to-move flag and a last-neuron
// mark. The block is ready only while its sequencer is idle. A neuron that is
// not the last one occupies the block during four passes through the single
// shared 34x17 multiplier and one accumulate step. The last neuron then also
// runs the finishing sequence, which holds two passes of the bit-serial
// divider, each keeping the sequencer waiting until its quotient is done; a
// zero clamp limit or output quantisation factor skips both divisions and gives
// an evaluation of zero.
// Output channel: one transfer per last neuron carrying the evaluation. The
// result sits in an output register, so the next neuron is accepted while the
// result waits; if the receiver stalls and a second result is ready, the
// sequencer holds that result until the output register is free.
// Configuration channel: always ready; writes are expected only while idle.
// Reset (synchronous, active low) restores the default register values, clears
// the running sum and empties the output register.
module screlu_output_layer_eval_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sole_in_if.sink     i_in,
    sole_cfg_if.sink    i_cfg,
    sole_out_if.source  o_out
);
    import sole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T0_MUL1,
        S_T0_MUL2,
        S_T1_MUL1,
        S_T1_MUL2,
        S_ACC,
        S_DIV1,
        S_DIV1_WAIT,
        S_BIAS,
        S_SCALE,
        S_QUANT,
        S_DIV2,
        S_DIV2_WAIT,
        S_EMIT
    } t_state;

    t_state                       r_state;

    // Configuration registers.
    logic [CLAMP_W-1:0]           r_clamp_limit;
    logic [QUANT_W-1:0]           r_output_quant;
    logic [SCALE_W-1:0]           r_eval_scale;
    logic signed [BIAS_W-1:0]     r_output_bias;

    // Per-neuron operands, already put in side-to-move order and clamped.
    logic [CLAMP_W-1:0]           r_c0;
    logic [CLAMP_W-1:0]           r_c1;
    logic signed [WGT_W-1:0]      r_w0;
    logic signed [WGT_W-1:0]      r_w1;
    logic                         r_last;

    logic [SUM_W-1:0]             r_sum;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [MA_W-1:0]       r_q;
    logic [DVD_W-1:0]             r_num_mag;
    logic                         r_neg;
    logic signed [EVAL_W-1:0]     r_res;

    logic                         r_out_valid;
    logic signed [EVAL_W-1:0]     r_eval;

    logic signed [ACC_W-1:0]      stm_acc;
    logic signed [ACC_W-1:0]      opp_acc;
    logic [CLAMP_W-1:0]           mover_clip;
    logic [CLAMP_W-1:0]           opp_clip;

    logic signed [MA_W-1:0]       mul_a;
    logic signed [MB_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]     mul_p;

    logic [SUM_W:0]               sum_mag;
    logic [MA_W-1:0]              q1_mag;
    logic [DVD_W-1:0]             prod_mag;
    logic                         div_by_zero;
    logic                         in_xfer;

    t_div_req                     div_req;
    t_div_rsp                     div_rsp;

    function automatic logic [CLAMP_W-1:0] clamp_act(
        input logic signed [ACC_W-1:0] acc,
        input logic [CLAMP_W-1:0]      limit
    );
        logic [CLAMP_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (acc[CLAMP_W-1:0] > limit) begin
            res = limit;
        end else begin
            res = acc[CLAMP_W-1:0];
        end
        return res;
    endfunction

    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Perspective ordering: the side to move is paired with own_weight.
    assign stm_acc    = i_in.white_moves ? i_in.wht_accum : i_in.blk_accum;
    assign opp_acc    = i_in.white_moves ? i_in.blk_accum : i_in.wht_accum;
    assign mover_clip = clamp_act(stm_acc, r_clamp_limit);
    assign opp_clip   = clamp_act(opp_acc, r_clamp_limit);

    // Operand selection for the one shared multiplier. Every product is
    // registered in r_prod before anything else uses it.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_T0_MUL1: begin
                mul_a = MA_W'(r_w0);
                mul_b = {2'b00, r_c0};
            end
            S_T0_MUL2: begin
                // The weight product is wrapped to 16 signed bits first.
                mul_a = MA_W'($signed(r_prod[WGT_W-1:0]));
                mul_b = {2'b00, r_c0};
            end
            S_T1_MUL1: begin
                mul_a = MA_W'(r_w1);
                mul_b = {2'b00, r_c1};
            end
            S_T1_MUL2: begin
                mul_a = MA_W'($signed(r_prod[WGT_W-1:0]));
                mul_b = {2'b00, r_c1};
            end
            S_SCALE: begin
                mul_a = r_q;
                mul_b = {1'b0, r_eval_scale};
            end
            S_QUANT: begin
                mul_a = {{(MA_W-CLAMP_W){1'b0}}, r_clamp_limit};
                mul_b = {2'b00, r_output_quant};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Magnitudes handed to the unsigned divider; signs are tracked in r_neg.
    assign sum_mag  = r_sum[SUM_W-1] ? ((SUM_W+1)'(0) - {1'b1, r_sum}) : {1'b0, r_sum};
    assign q1_mag   = {1'b0, div_rsp.quotient[MA_W-2:0]};
    assign prod_mag = r_prod[PROD_W-1] ? DVD_W'(-r_prod) : DVD_W'(r_prod);

    assign div_by_zero = (r_clamp_limit == '0) || (r_output_quant == '0);

    always_comb begin
        div_req = '0;
        case (r_state)
            S_DIV1: begin
                div_req.start    = !div_by_zero;
                div_req.dividend = DVD_W'(sum_mag);
                div_req.divisor  = {{(DSR_W-CLAMP_W){1'b0}}, r_clamp_limit};
            end
            S_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_num_mag;
                div_req.divisor  = r_prod[DSR_W-1:0];
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    sole_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_clamp_limit  <= RST_CLAMP_LIMIT;
            r_output_quant <= RST_OUTPUT_QUANT;
            r_eval_scale   <= RST_EVAL_SCALE;
            r_output_bias  <= RST_OUTPUT_BIAS;
            r_sum          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_IDX_CLAMP_LIMIT:  r_clamp_limit  <= i_cfg.data[CLAMP_W-1:0];
                    CFG_IDX_OUTPUT_QUANT: r_output_quant <= i_cfg.data[QUANT_W-1:0];
                    CFG_IDX_EVAL_SCALE:   r_eval_scale   <= i_cfg.data[SCALE_W-1:0];
                    CFG_IDX_OUTPUT_BIAS:  r_output_bias  <= $signed(i_cfg.data[BIAS_W-1:0]);
                    default: begin
                    end
                endcase
            end

            // A new result fills the output register as soon as it is empty
            // or its current transfer completes in this cycle.
            if (r_state == S_EMIT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_c0    <= mover_clip;
                        r_c1    <= opp_clip;
                        r_w0    <= i_in.own_weight;
                        r_w1    <= i_in.other_weight;
                        r_last  <= i_in.last_neuron;
                        r_state <= S_T0_MUL1;
                    end
                end
                S_T0_MUL1: begin
                    r_prod  <= mul_p;
                    r_state <= S_T0_MUL2;
                end
                S_T0_MUL2: begin
                    r_prod  <= mul_p;
                    r_state <= S_T1_MUL1;
                end
                S_T1_MUL1: begin
                    // The side-to-move term joins the sum as the next
                    // product starts.
                    r_sum   <= r_sum + r_prod[SUM_W-1:0];
                    r_prod  <= mul_p;
                    r_state <= S_T1_MUL2;
                end
                S_T1_MUL2: begin
                    r_prod  <= mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum   <= r_sum + r_prod[SUM_W-1:0];
                    r_state <= r_last ? S_DIV1 : S_IDLE;
                end
                S_DIV1: begin
                    // The divider latches the magnitude at this same edge, so the sum can
                    // be cleared here for the next position.
                    r_sum <= '0;
                    r_neg <= r_sum[SUM_W-1];
                    if (div_by_zero) begin
                        r_res   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV1_WAIT;
                    end
                end
                S_DIV1_WAIT: begin
                    if (div_rsp.done) begin
                        r_q     <= r_neg ? $signed(MA_W'(0) - q1_mag) : $signed(q1_mag);
                        r_state <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    r_q     <= r_q + MA_W'(r_output_bias);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod  <= mul_p;
                    r_state <= S_QUANT;
                end
                S_QUANT: begin
                    // The scaled numerator moves out of r_prod as the final
                    // divisor is formed in it.
                    r_neg     <= r_prod[PROD_W-1];
                    r_num_mag <= prod_mag;
                    r_prod    <= mul_p;
                    r_state   <= S_DIV2;
                end
                S_DIV2: begin
                    r_state <= S_DIV2_WAIT;
                end
                S_DIV2_WAIT: begin
                    if (div_rsp.done) begin
                        // Saturate the quotient to the signed 32-bit range.
                        if (r_neg) begin
                            if (div_rsp.quotient > DVD_W'(33'h0_8000_0000)) begin
                                r_res <= EVAL_MIN;
                            end else begin
                                r_res <= $signed(EVAL_W'(0) - div_rsp.quotient[EVAL_W-1:0]);
                            end
                        end else begin
                            if (div_rsp.quotient > DVD_W'(32'h7FFF_FFFF)) begin
                                r_res <= EVAL_MAX;
                            end else begin
                                r_res <= $signed(div_rsp.quotient[EVAL_W-1:0]);
                            end
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_eval  <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.evaluation = r_eval;

`ifndef NO_ASSERTIONS
    // The divider is never restarted while a division is still running.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A division result only ever arrives while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV1_WAIT || r_state == S_DIV2_WAIT))
        else $error("division finished outside a wait state");

    // A neuron without the last mark never starts the finishing sequence.
    a_not_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && !r_last) |=> (r_state == S_IDLE))
        else $error("finishing sequence entered for a non-final neuron");

    // The running sum is already cleared by the time a result is emitted.
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_sum == '0))
        else $error("running sum not cleared before result");
`endif

endmodule

/* design/sole_div.sv */
module sole_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sole_pkg::t_div_req  i_req,
    output sole_pkg::t_div_rsp  o_rsp
);
    import sole_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DCNT_W-1:0]    r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [DSR_W-1:0]     r_rem;
    logic [DSR_W-1:0]     r_dsr;

    logic [DSR_W:0]       rem_sh;
    logic [DSR_W+1:0]     trial;
    logic                 q_bit;

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out at the top while quotient bits enter at the bottom.
    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dsr};
    assign q_bit  = ~trial[DSR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
                r_rem <= q_bit ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Block-level testbench for the SCReLU output layer evaluator.
//
// Neurons are sent one transfer at a time on the input channel. Every accepted
// neuron is folded into a local copy of the running sum. A neuron marked last
// closes a position, and the evaluation that the block should return for it
// is queued. A separate process on the output channel takes each evaluation
// transfer and compares it with the oldest queued value. Register writes go
// out only while the block is idle, and the same writes update the local copy
// of the registers.
module testbench;
    import sole_pkg::*;

    localparam int IDLE_PCT       = 24;    // chance in a hundred of idling
    localparam int HOLD_CYCLES    = 800;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 150;   // covers a full finishing sequence
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
    localparam int TOTAL_ITEMS    = 650;

    typedef struct packed {
        logic signed [ACC_W-1:0] wht_accum;
        logic signed [ACC_W-1:0] blk_accum;
        logic signed [WGT_W-1:0] own_weight;
        logic signed [WGT_W-1:0] other_weight;
        logic                    white_moves;
        logic                    last_neuron;
    } t_neuron;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sole_in_if  neuron_if ();
    sole_cfg_if reg_if ();
    sole_out_if eval_if ();

    screlu_output_layer_eval_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (neuron_if),
        .i_cfg   (reg_if),
        .o_out   (eval_if)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the registers and of the running sum.
    logic [CLAMP_W-1:0]       cur_clamp_limit;
    logic [QUANT_W-1:0]       cur_output_quant;
    logic [SCALE_W-1:0]       cur_eval_scale;
    logic signed [BIAS_W-1:0] cur_output_bias;
    logic [SUM_W-1:0]         neuron_sum;

    // Evaluations still owed by the block, oldest first.
    logic signed [EVAL_W-1:0] expected_evals[$];
    logic signed [EVAL_W-1:0] want_eval;

    int  fail_count  = 0;
    int  sent_count  = 0;
    int  quiet_cycles = 0;
    // The stimulus bumps stall_req to ask for a long hold-off; the receiver
    // process notices the change and counts the hold-off down itself.
    int  stall_req   = 0;
    int  stall_ack   = 0;
    int  stall_left  = 0;
    // While calm is set neither side idles.
    logic calm = 1'b0;

    // One activation term: the accumulator is clamped to 0..clamp_limit, the
    // product with the weight is wrapped to 16 signed bits and then multiplied
    // by the clamped value once more. Only the low 32 bits go into the sum.
    function automatic logic [SUM_W-1:0] clamped_square_term(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [WGT_W-1:0] weight);
        longint           c;
        longint           p;
        logic signed [15:0] wrapped;
        c = acc;
        if (c < 0)
            c = 0;
        if (c > longint'(cur_clamp_limit))
            c = longint'(cur_clamp_limit);
        p = longint'(weight) * c;
        wrapped = p[15:0];
        p = longint'(wrapped) * c;
        return p[SUM_W-1:0];
    endfunction

    // Finishing arithmetic of a position. Both divisions truncate toward zero;
    // a zero divisor gives an evaluation of zero, and the final value is
    // saturated to the signed 32-bit range.
    function automatic logic signed [EVAL_W-1:0] scaled_evaluation();
        longint s;
        longint q;
        longint div2;
        s    = longint'($signed(neuron_sum));
        div2 = longint'(cur_clamp_limit) * longint'(cur_output_quant);
        if (cur_clamp_limit == '0 || div2 == 0)
            return '0;
        q = s / longint'(cur_clamp_limit);
        q = (q + longint'(cur_output_bias)) * longint'(cur_eval_scale);
        q = q / div2;
        if (q > longint'(EVAL_MAX))
            q = longint'(EVAL_MAX);
        if (q < longint'(EVAL_MIN))
            q = longint'(EVAL_MIN);
        return q[EVAL_W-1:0];
    endfunction

    // The side-to-move flag decides which accumulator meets which weight.
    function automatic void fold_neuron(input t_neuron n);
        logic signed [ACC_W-1:0] own_acc;
        logic signed [ACC_W-1:0] other_acc;
        own_acc   = n.white_moves ? n.wht_accum : n.blk_accum;
        other_acc = n.white_moves ? n.blk_accum : n.wht_accum;
        neuron_sum = neuron_sum + clamped_square_term(own_acc, n.own_weight)
                     + clamped_square_term(other_acc, n.other_weight);
        if (n.last_neuron) begin
            expected_evals.push_back(scaled_evaluation());
            neuron_sum = '0;
        end
    endfunction

    function automatic void record_register_write(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IDX_CLAMP_LIMIT:  cur_clamp_limit  = data[CLAMP_W-1:0];
            CFG_IDX_OUTPUT_QUANT: cur_output_quant = data[QUANT_W-1:0];
            CFG_IDX_EVAL_SCALE:   cur_eval_scale   = data[SCALE_W-1:0];
            CFG_IDX_OUTPUT_BIAS:  cur_output_bias  = data[BIAS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_neuron make_neuron(
        input logic signed [ACC_W-1:0] wa, input logic signed [ACC_W-1:0] ba,
        input logic signed [WGT_W-1:0] ow, input logic signed [WGT_W-1:0] tw,
        input logic wm, input logic last);
        t_neuron n;
        n.wht_accum    = wa;
        n.blk_accum    = ba;
        n.own_weight   = ow;
        n.other_weight = tw;
        n.white_moves  = wm;
        n.last_neuron  = last;
        return n;
    endfunction

    // Accumulators are mostly drawn around the clamp range so that both clamp
    // edges are met often; the rest are extremes or the full 16-bit range.
    function automatic logic signed [ACC_W-1:0] random_acc();
        int v;
        case ($urandom_range(9))
            0: v = $urandom_range(1) ? 32767 : -32768;
            1, 2: v = $signed($urandom_range(65535) - 32768);
            3: v = int'(cur_clamp_limit) + int'($urandom_range(4)) - 2;
            default: v = int'($urandom_range(cur_clamp_limit + 16)) - 8;
        endcase
        if (v > 32767)
            v = 32767;
        return v[ACC_W-1:0];
    endfunction

    function automatic logic signed [WGT_W-1:0] random_weight();
        int v;
        case ($urandom_range(9))
            0: v = $urandom_range(1) ? 32767 : -32768;
            1, 2, 3, 4: v = $signed($urandom_range(65535) - 32768);
            default: v = int'($urandom_range(1023)) - 512;
        endcase
        return v[WGT_W-1:0];
    endfunction

    // Sends one neuron and returns at the clock edge where it was accepted.
    // Valid is left high on return so that a following neuron can go out
    // back to back; any caller that waits instead must lower it first.
    task automatic send_neuron(input t_neuron n);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            neuron_if.valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
        neuron_if.valid        <= 1'b1;
        neuron_if.wht_accum    <= n.wht_accum;
        neuron_if.blk_accum    <= n.blk_accum;
        neuron_if.own_weight   <= n.own_weight;
        neuron_if.other_weight <= n.other_weight;
        neuron_if.white_moves  <= n.white_moves;
        neuron_if.last_neuron  <= n.last_neuron;
        do @(posedge i_clk); while (!neuron_if.ready);
        fold_neuron(n);
        sent_count++;
    endtask

    // A position of len neurons with random content, the last one marked.
    task automatic send_position(input int len);
        for (int i = 0; i < len; i++)
            send_neuron(make_neuron(random_acc(), random_acc(), random_weight(),
                                    random_weight(), 1'($urandom_range(1)),
                                    i == len - 1));
    endtask

    task automatic wait_for_results();
        neuron_if.valid <= 1'b0;
        while (expected_evals.size() != 0) @(posedge i_clk);
    endtask

    // A neuron that is not last gives no result, so the block may still be
    // busy once the queue is empty; the extra cycles cover the longest
    // sequence before a register is touched.
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= data;
        do @(posedge i_clk); while (!reg_if.ready);
        record_register_write(idx, data);
        reg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The top bit of the 15-bit registers is random: it lies outside the
    // register and must be dropped.
    task automatic write_config(input logic [CLAMP_W-1:0] clamp,
                                input logic [QUANT_W-1:0] quant,
                                input logic [SCALE_W-1:0] scale,
                                input logic [BIAS_W-1:0]  bias);
        logic pad;
        settle();
        pad = 1'($urandom_range(1));
        write_register(CFG_IDX_CLAMP_LIMIT, {pad, clamp});
        pad = 1'($urandom_range(1));
        write_register(CFG_IDX_OUTPUT_QUANT, {pad, quant});
        write_register(CFG_IDX_EVAL_SCALE, scale);
        write_register(CFG_IDX_OUTPUT_BIAS, bias);
    endtask

    function automatic logic [CLAMP_W-1:0] random_divisor();
        case ($urandom_range(15))
            0: return '0;
            1, 2: return 15'd1;
            3, 4: return 15'h7FFF;
            5, 6: return 15'($urandom_range(1024, 1));
            7: return 15'd255;
            default: return 15'($urandom_range(32767, 1));
        endcase
    endfunction

    task automatic randomise_config();
        logic [SCALE_W-1:0] scale;
        logic [BIAS_W-1:0]  bias;
        case ($urandom_range(3))
            0: scale = $urandom_range(1) ? 16'hFFFF : 16'd1;
            default: scale = 16'($urandom_range(65535, 1));
        endcase
        case ($urandom_range(3))
            0: bias = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            1: bias = 16'($urandom_range(64) - 32);
            default: bias = 16'($urandom_range(65535));
        endcase
        write_config(random_divisor(), random_divisor(), scale, bias);
    endtask

    // Register values straight after reset; extremes of every input field,
    // both perspectives, accumulators on and just past the clamp edges.
    task automatic test_reset_registers();
        send_neuron(make_neuron(0, 0, 0, 0, 1'b0, 1'b1));
        send_neuron(make_neuron(32767, -32768, 32767, -32768, 1'b1, 1'b1));
        send_neuron(make_neuron(32767, -32768, 32767, -32768, 1'b0, 1'b1));
        send_neuron(make_neuron(255, 256, -32768, 32767, 1'b1, 1'b0));
        send_neuron(make_neuron(-1, 254, 32767, -32767, 1'b0, 1'b1));
        send_neuron(make_neuron(200, -200, 12345, -12345, 1'b1, 1'b1));
    endtask

    // Smallest divisors with the largest scale push the final value past
    // both ends of the 32-bit range.
    task automatic test_saturation();
        write_config(15'd1, 15'd1, 16'hFFFF, 16'h7FFF);
        send_neuron(make_neuron(32767, 32767, 32767, 32767, 1'b1, 1'b1));
        write_config(15'd1, 15'd1, 16'hFFFF, 16'h8000);
        send_neuron(make_neuron(32767, 32767, -32768, -32768, 1'b0, 1'b1));
    endtask

    // A zero clamp limit or a zero quantisation factor gives zero.
    task automatic test_zero_divisors();
        write_config(15'd0, 15'd64, 16'd400, 16'd0);
        send_neuron(make_neuron(100, 200, 300, -400, 1'b1, 1'b1));
        write_config(15'd255, 15'd0, 16'd400, 16'd0);
        send_neuron(make_neuron(100, 200, 300, -400, 1'b0, 1'b1));
    endtask

    // Widest clamp: each term comes close to -2^30 and each neuron adds two,
    // so the three neurons wrap the 32-bit sum.
    task automatic test_widest_registers();
        write_config(15'h7FFF, 15'h7FFF, 16'd1, 16'hFFFF);
        send_neuron(make_neuron(32767, 32767, -1, -1, 1'b1, 1'b0));
        send_neuron(make_neuron(32767, 32767, -1, -1, 1'b0, 1'b0));
        send_neuron(make_neuron(32767, 32767, -1, -1, 1'b1, 1'b1));
        send_neuron(make_neuron(20000, -5, 32767, 1, 1'b0, 1'b1));
    endtask

    // The receiver holds off while one-neuron positions keep coming, so the
    // output register and the sequencer fill and the input stalls. Then the
    // sender stops until every result is in before carrying on.
    task automatic test_output_backpressure();
        write_config(RST_CLAMP_LIMIT, RST_OUTPUT_QUANT, RST_EVAL_SCALE,
                     RST_OUTPUT_BIAS);
        stall_req <= stall_req + 1;
        repeat (16) send_position(1);
        wait_for_results();
        repeat (8) send_position($urandom_range(3, 1));
    endtask

    // Phases of random positions, each with a fresh register setting. One
    // phase runs with neither side idling.
    task automatic test_random_positions();
        int phase;
        int positions;
        phase = 0;
        while (sent_count < TOTAL_ITEMS) begin
            randomise_config();
            calm <= (phase == 2);
            positions = $urandom_range(30, 15);
            repeat (positions)
                send_position(($urandom_range(9) == 0) ? $urandom_range(40, 7)
                                                       : $urandom_range(6, 1));
            phase++;
        end
        calm <= 1'b0;
    endtask

    // Output side: checks every evaluation transfer and drives ready, with
    // random idling and the long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            eval_if.ready <= 1'b0;
        end else begin
            if (eval_if.valid && eval_if.ready) begin
                if (expected_evals.size() == 0) begin
                    $error("evaluation unexpected: actual %0d", eval_if.evaluation);
                    fail_count++;
                end else begin
                    want_eval = expected_evals.pop_front();
                    if (eval_if.evaluation !== want_eval) begin
                        $error("evaluation mismatch: expected %0d, actual %0d",
                               want_eval, eval_if.evaluation);
                        fail_count++;
                    end
                end
            end
            if (stall_req != stall_ack) begin
                stall_ack  = stall_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                eval_if.ready <= 1'b0;
            end else if (calm) begin
                eval_if.ready <= 1'b1;
            end else begin
                eval_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Ends the run if no channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (neuron_if.valid && neuron_if.ready)
                || (eval_if.valid && eval_if.ready)
                || (reg_if.valid && reg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("screlu_output_layer_eval_core verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        neuron_if.valid        <= 1'b0;
        neuron_if.wht_accum    <= '0;
        neuron_if.blk_accum    <= '0;
        neuron_if.own_weight   <= '0;
        neuron_if.other_weight <= '0;
        neuron_if.white_moves  <= 1'b0;
        neuron_if.last_neuron  <= 1'b0;
        reg_if.valid           <= 1'b0;
        reg_if.index           <= CFG_IDX_CLAMP_LIMIT;
        reg_if.data            <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur_clamp_limit  = RST_CLAMP_LIMIT;
        cur_output_quant = RST_OUTPUT_QUANT;
        cur_eval_scale   = RST_EVAL_SCALE;
        cur_output_bias  = RST_OUTPUT_BIAS;
        neuron_sum       = '0;
        @(posedge i_clk);

        test_reset_registers();
        test_saturation();
        test_zero_divisors();
        test_widest_registers();
        test_output_backpressure();
        test_random_positions();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("screlu_output_layer_eval_core verification clean");
        else
            $display("screlu_output_layer_eval_core verification failed");
        $finish;
    end

endmodule
